FILE: sv/tgac_pkg.sv
// Shared types, constants and register map of the tile grid average color block.
`default_nettype none
package tgac_pkg;

    localparam int MAX_GRID_COLS_DEF = 256;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int MAX_IMAGE_DIM     = 4096;
    localparam int GRID_ROW_LIMIT    = 256;

    localparam int DIM_W = 13;
    localparam int CNT_W = 9;
    localparam int POS_W = 12;
    localparam int SUM_W = 40;
    localparam int DEN_W = 25;
    localparam int PIX_W = 16;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CNT_W-1:0] COLS_RESET   = 9'd16;
    localparam logic [CNT_W-1:0] ROWS_RESET   = 9'd12;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_GRID_COLUMNS = 2'd2,
        REG_GRID_ROWS    = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_BX1,
        OP_BY1,
        OP_NXB,
        OP_NYB,
        OP_RED,
        OP_GREEN,
        OP_BLUE
    } t_div_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_ACC,
        S_ROUTE,
        S_DIV,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    restart;
        logic    rd;
        logic    acc;
        logic    div_start;
        logic    div_capture;
        logic    load_out;
        t_div_op div_op;
    } t_cmd;

    typedef struct packed {
        logic restart_req;
        logic emit;
        logic need_x;
        logic need_y;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/tgac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tgac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/tgac_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tgac_div
    import tgac_pkg::*;
#(
    parameter int NUM_W = SUM_W,
    parameter int DW    = DEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DW-1:0]    i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   shifted;
    logic          fits;

    assign shifted = {r_rem, r_q[NUM_W-1]};
    assign fits    = shifted >= {1'b0, r_den};
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DW'(shifted - {1'b0, r_den});
            end else begin
                r_rem <= shifted[DW-1:0];
            end
            r_q <= {r_q[NUM_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

FILE: sv/tgac_ctrl.sv
// Sequencer for pixel intake, sum update, mean division and boundary updates.
`default_nettype none
module tgac_ctrl
    import tgac_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_sts,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state  r_state, n_state;
    t_div_op r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_BX1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.div_op = r_op;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.restart_req) begin
                    o_cmd.restart = 1'b1;
                    n_op    = OP_BX1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_ROUTE;
            end
            S_ROUTE: begin
                if (i_sts.emit) begin
                    n_op    = OP_RED;
                    n_state = S_DIV;
                end else if (i_sts.need_x) begin
                    n_op    = OP_NXB;
                    n_state = S_DIV;
                end else if (i_sts.need_y) begin
                    n_op    = OP_NYB;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    n_state = S_DIV;
                    case (r_op)
                        OP_BX1:   n_op = OP_BY1;
                        OP_BY1:   n_state = S_READ;
                        OP_RED:   n_op = OP_GREEN;
                        OP_GREEN: n_op = OP_BLUE;
                        OP_BLUE:  n_state = S_OUT;
                        OP_NXB: begin
                            if (i_sts.need_y) begin
                                n_op = OP_NYB;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.need_x) begin
                        n_op    = OP_NXB;
                        n_state = S_DIV;
                    end else if (i_sts.need_y) begin
                        n_op    = OP_NYB;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/tgac_dp.sv
// Datapath: configuration registers, raster position, column sums, divider and output register.
`default_nettype none
module tgac_dp
    import tgac_pkg::*;
#(
    parameter int MAX_GRID_COLS = MAX_GRID_COLS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_fire,
    input  wire logic [47:0] i_in_data,
    input  wire logic        i_in_first,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic      [63:0] o_out_data,
    output logic             o_out_last,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    output logic      [31:0] o_cfg_rdata,
    input  wire t_cmd        i_cmd,
    output t_status          o_sts
);

    localparam int AW = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
    localparam logic [PIX_W-1:0] SMASK = PIX_W'((17'(1) << SAMPLE_BITS) - 17'(1));

    logic [DIM_W-1:0] r_width, r_height;
    logic [CNT_W-1:0] r_cols, r_rows;
    logic             r_pend;

    logic [DIM_W-1:0] ew, eh, xtop, ytop;
    logic [CNT_W-1:0] cv, rv, ec, er;

    logic [PIX_W-1:0] r_pr, r_pg, r_pb;
    logic             r_fs;

    logic [POS_W-1:0] r_px, r_py, r_sx, r_rsy;
    logic [CNT_W-1:0] r_col, r_row;
    logic [DIM_W-1:0] r_nxb, r_nyb, r_bx1, r_by1;

    logic [SUM_W-1:0] r_sr, r_sg, r_sb;
    logic [DEN_W-1:0] r_area;
    logic             r_emit, r_need_x, r_need_y, r_elast;
    logic [7:0]       r_erow, r_ecol;
    logic [PIX_W-1:0] r_mr, r_mg, r_mb;

    logic [3*SUM_W-1:0] rd_data, wr_data;
    logic [AW-1:0]      idx;
    logic               first_line, col_end, row_end, xwrap, ywrap;
    logic [SUM_W-1:0]   nr, ng, nb;
    logic [DIM_W-1:0]   npx, npy;
    logic [CNT_W-1:0]   ncol, nrow;
    logic [DIM_W-1:0]   dx, dy;
    logic [25:0]        prod;

    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_num, div_quot;
    logic [DEN_W-1:0]   div_den;

    // effective sizes and grid counts
    always_comb begin
        ew = (r_width == '0) ? DIM_W'(1) :
             (r_width > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : r_width;
        eh = (r_height == '0) ? DIM_W'(1) :
             (r_height > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : r_height;
        xtop = (ew < DIM_W'(MAX_GRID_COLS)) ? ew : DIM_W'(MAX_GRID_COLS);
        ytop = (eh < DIM_W'(GRID_ROW_LIMIT)) ? eh : DIM_W'(GRID_ROW_LIMIT);
        cv = (r_cols == '0) ? CNT_W'(1) : r_cols;
        rv = (r_rows == '0) ? CNT_W'(1) : r_rows;
        ec = ({4'b0, cv} > xtop) ? CNT_W'(xtop) : cv;
        er = ({4'b0, rv} > ytop) ? CNT_W'(ytop) : rv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_cols   <= COLS_RESET;
            r_rows   <= ROWS_RESET;
            r_pend   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_pend <= 1'b1;
                case (t_reg_idx'(i_cfg_idx))
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[DIM_W-1:0];
                    REG_GRID_COLUMNS: r_cols   <= i_cfg_wdata[CNT_W-1:0];
                    REG_GRID_ROWS:    r_rows   <= i_cfg_wdata[CNT_W-1:0];
                    default:          r_width  <= r_width;
                endcase
            end else if (i_cmd.restart) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_comb begin
        case (t_reg_idx'(i_cfg_idx))
            REG_IMAGE_WIDTH:  o_cfg_rdata = 32'(r_width);
            REG_IMAGE_HEIGHT: o_cfg_rdata = 32'(r_height);
            REG_GRID_COLUMNS: o_cfg_rdata = 32'(r_cols);
            REG_GRID_ROWS:    o_cfg_rdata = 32'(r_rows);
            default:          o_cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_pr <= i_in_data[15:0] & SMASK;
            r_pg <= i_in_data[31:16] & SMASK;
            r_pb <= i_in_data[47:32] & SMASK;
            r_fs <= i_in_first;
        end
    end

    // sum update and position advance
    assign idx        = AW'(r_col);
    assign first_line = (r_py == r_rsy);
    assign nr = first_line ? SUM_W'(r_pr) : rd_data[SUM_W-1:0] + SUM_W'(r_pr);
    assign ng = first_line ? SUM_W'(r_pg) : rd_data[2*SUM_W-1:SUM_W] + SUM_W'(r_pg);
    assign nb = first_line ? SUM_W'(r_pb) : rd_data[3*SUM_W-1:2*SUM_W] + SUM_W'(r_pb);
    assign wr_data = {nb, ng, nr};

    assign col_end = (({1'b0, r_px} + DIM_W'(1)) == r_nxb);
    assign row_end = (({1'b0, r_py} + DIM_W'(1)) == r_nyb);
    assign npx     = {1'b0, r_px} + DIM_W'(1);
    assign npy     = {1'b0, r_py} + DIM_W'(1);
    assign ncol    = col_end ? r_col + CNT_W'(1) : r_col;
    assign nrow    = row_end ? r_row + CNT_W'(1) : r_row;
    assign xwrap   = (npx >= ew) || (ncol >= ec);
    assign ywrap   = (npy >= eh) || (nrow >= er);
    assign dx      = r_nxb - {1'b0, r_sx};
    assign dy      = r_nyb - {1'b0, r_rsy};
    assign prod    = 26'(dx * dy);

    tgac_ram #(
        .WIDTH (3*SUM_W),
        .DEPTH (MAX_GRID_COLS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc),
        .i_waddr (idx),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd),
        .i_raddr (idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px     <= '0;
            r_py     <= '0;
            r_sx     <= '0;
            r_rsy    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_emit   <= 1'b0;
            r_need_x <= 1'b0;
            r_need_y <= 1'b0;
        end else if (i_cmd.restart) begin
            r_px  <= '0;
            r_py  <= '0;
            r_sx  <= '0;
            r_rsy <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.acc) begin
            r_emit   <= col_end && row_end;
            r_need_x <= col_end && !xwrap;
            r_need_y <= xwrap && row_end && !ywrap;
            if (xwrap) begin
                r_px  <= '0;
                r_col <= '0;
                r_sx  <= '0;
                if (ywrap) begin
                    r_py  <= '0;
                    r_row <= '0;
                    r_rsy <= '0;
                end else begin
                    r_py  <= npy[POS_W-1:0];
                    r_row <= nrow;
                    if (row_end) begin
                        r_rsy <= r_nyb[POS_W-1:0];
                    end
                end
            end else begin
                r_px  <= npx[POS_W-1:0];
                r_col <= ncol;
                if (col_end) begin
                    r_sx <= r_nxb[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_sr    <= nr;
            r_sg    <= ng;
            r_sb    <= nb;
            r_area  <= (prod == '0) ? DEN_W'(1) : DEN_W'(prod);
            r_erow  <= r_row[7:0];
            r_ecol  <= r_col[7:0];
            r_elast <= (({1'b0, r_col} + 10'd1) == {1'b0, ec}) &&
                       (({1'b0, r_row} + 10'd1) == {1'b0, er});
            if (xwrap) begin
                r_nxb <= r_bx1;
                if (ywrap) begin
                    r_nyb <= r_by1;
                end
            end
        end else if (i_cmd.div_capture) begin
            case (i_cmd.div_op)
                OP_BX1: begin
                    r_bx1 <= div_quot[DIM_W-1:0];
                    r_nxb <= div_quot[DIM_W-1:0];
                end
                OP_BY1: begin
                    r_by1 <= div_quot[DIM_W-1:0];
                    r_nyb <= div_quot[DIM_W-1:0];
                end
                OP_NXB:   r_nxb <= div_quot[DIM_W-1:0];
                OP_NYB:   r_nyb <= div_quot[DIM_W-1:0];
                OP_RED:   r_mr  <= div_quot[PIX_W-1:0];
                OP_GREEN: r_mg  <= div_quot[PIX_W-1:0];
                OP_BLUE:  r_mb  <= div_quot[PIX_W-1:0];
                default:  r_mr  <= r_mr;
            endcase
        end
    end

    // divider operand select
    always_comb begin
        case (i_cmd.div_op)
            OP_BX1, OP_NXB: begin
                div_num = SUM_W'(ew * ({1'b0, r_col} + 10'd1));
                div_den = DEN_W'(ec);
            end
            OP_BY1, OP_NYB: begin
                div_num = SUM_W'(eh * ({1'b0, r_row} + 10'd1));
                div_den = DEN_W'(er);
            end
            OP_RED: begin
                div_num = r_sr;
                div_den = r_area;
            end
            OP_GREEN: begin
                div_num = r_sg;
                div_den = r_area;
            end
            OP_BLUE: begin
                div_num = r_sb;
                div_den = r_area;
            end
            default: begin
                div_num = r_sr;
                div_den = r_area;
            end
        endcase
    end

    assign div_start = i_cmd.div_start;

    tgac_div #(
        .NUM_W (SUM_W),
        .DW    (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_data <= {r_mb, r_mg, r_mr, r_ecol, r_erow};
            o_out_last <= r_elast;
        end
    end

    assign o_sts.restart_req = r_fs || r_pend;
    assign o_sts.emit        = r_emit;
    assign o_sts.need_x      = r_need_x;
    assign o_sts.need_y      = r_need_y;
    assign o_sts.div_done    = div_done;
    assign o_sts.out_busy    = o_out_valid && !i_out_ready;

endmodule
`default_nettype wire

FILE: sv/tile_grid_average_color_top.sv
// Top level of the tile grid average color block.
// Takes RGB pixels in raster order and emits, for each grid region, the
// truncated mean of each channel once the region's bottom-right pixel is in.
// One pixel is taken at a time: a plain pixel passes through start, read,
// sum update and route, then goes back to idle. A pixel that ends a region adds
// three 40-step divisions of the shared restoring divider for the means,
// and a pixel that ends a region column or row adds one
// 40-step boundary division on the same divider. The first pixel after
// reset, a register write or a frame_start pixel adds two more boundary
// divisions. A finished result waits in the output register while the
// next pixel is taken.
`default_nettype none
module tile_grid_average_color_top
    import tgac_pkg::*;
#(
    parameter int MAX_GRID_COLS = MAX_GRID_COLS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    input  wire logic        s_axis_tuser,  // frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,  // region_row, region_col, mean_red, mean_green, mean_blue
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cmd    cmd;
    t_status sts;
    logic    in_fire;
    logic    cfg_we;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    tgac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    tgac_dp #(
        .MAX_GRID_COLS (MAX_GRID_COLS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_in_data   (s_axis_tdata),
        .i_in_first  (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (paddr[3:2]),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire
